// ===== rtl/core/utf16le_to_utf8_converter_assert.svh =====
`ifndef UTF16LE_TO_UTF8_CONVERTER_ASSERT_SVH
`define UTF16LE_TO_UTF8_CONVERTER_ASSERT_SVH

// Assertion sampled on clk, switched off while reset is held
`define U16U8_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion sampled on clk, active during reset as well
`define U16U8_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/u16u8_pkg.sv =====
package u16u8_pkg;

  // Job queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [15:0] CAP_RESET   = 16'd144;
  localparam logic [20:0] CP_REPLACE  = 21'h00fffd;
  localparam logic [20:0] CP_SUPP_OFS = 21'h010000;
  localparam logic [5:0]  SURR_HIGH   = 6'b110110;
  localparam logic [5:0]  SURR_LOW    = 6'b110111;

  // One character's worth of work for the back end
  typedef struct packed {
    logic [20:0] cp;      // code point
    logic [2:0]  nbytes;  // data bytes, 0..4
    logic        term;    // terminator follows the data bytes
  } job_t;

  // Byte idx of the UTF-8 encoding of cp, n bytes long
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] n,
                                           input logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case ({n, idx})
      {3'd1, 2'd0}: b = {1'b0, cp[6:0]};
      {3'd2, 2'd0}: b = {3'b110, cp[10:6]};
      {3'd2, 2'd1}: b = {2'b10, cp[5:0]};
      {3'd3, 2'd0}: b = {4'b1110, cp[15:12]};
      {3'd3, 2'd1}: b = {2'b10, cp[11:6]};
      {3'd3, 2'd2}: b = {2'b10, cp[5:0]};
      {3'd4, 2'd0}: b = {5'b11110, cp[20:18]};
      {3'd4, 2'd1}: b = {2'b10, cp[17:12]};
      {3'd4, 2'd2}: b = {2'b10, cp[11:6]};
      {3'd4, 2'd3}: b = {2'b10, cp[5:0]};
      default:      b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/core/utf16le_to_utf8_converter.sv =====
// Latency: the first byte of a job shows on the out ports the cycle after the job is
// written when the job queue is empty; its later bytes follow one per cycle while pop is held.
// Throughput: one item per cycle at the input while the four-entry job queue has room.
// The byte-serialising back end sets the sustained rate: a unit yields no bytes or up to
// three data bytes (four when a low surrogate completes a pair), plus a terminator.
// Reset (synchronous, rst_n low): queue emptied, string state cleared, capacity 144.
module utf16le_to_utf8_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        push,
  output logic        full,
  input  logic [15:0] in_code_unit,
  input  logic        in_end_of_string,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_out_byte,
  output logic        out_is_last
);
  import u16u8_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  job_t wr_job, rd_job;

  assign full = q_full;

  // Front: classify units, track surrogates and room
  u16u8_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (push),
    .in_code_unit     (in_code_unit),
    .in_end_of_string (in_end_of_string),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_job            (wr_job)
  );

  // Job queue
  u16u8_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_push),
    .wr_job (wr_job),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_job (rd_job),
    .empty  (q_empty)
  );

  // Back: one UTF-8 byte per pop
  u16u8_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_job        (rd_job),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .out_out_byte (out_out_byte),
    .out_is_last  (out_is_last)
  );

endmodule

// ===== rtl/core/u16u8_front.sv =====
module u16u8_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  input  logic                in_valid,
  input  logic [15:0]         in_code_unit,
  input  logic                in_end_of_string,
  input  logic                q_full,
  output logic                q_push,
  output u16u8_pkg::job_t     q_job
);
  import u16u8_pkg::*;

  logic [15:0] cap_r;
  logic        pending_r, pending_nxt;
  logic [9:0]  high_r, high_nxt;
  logic [15:0] bw_r, bw_nxt;
  logic        halted_r, halted_nxt;

  logic        accept;
  logic        is_hi, is_lo;
  logic        have_cp;
  logic [20:0] cp;
  logic [2:0]  n;
  logic [16:0] bw_sum;
  logic        fits;
  logic        stop;

  assign accept = in_valid && !q_full;
  assign is_hi  = (in_code_unit[15:10] == SURR_HIGH);
  assign is_lo  = (in_code_unit[15:10] == SURR_LOW);

  // Classify the unit and work out the code point it completes
  always_comb begin
    have_cp = 1'b0;
    cp      = 21'd0;
    if (pending_r) begin
      have_cp = 1'b1;
      cp = is_lo ? ({1'b0, high_r, in_code_unit[9:0]} + CP_SUPP_OFS) : CP_REPLACE;
    end else if (is_hi && !in_end_of_string) begin
      have_cp = 1'b0;
    end else if (is_hi || is_lo) begin
      have_cp = 1'b1;
      cp = CP_REPLACE;
    end else begin
      have_cp = 1'b1;
      cp = {5'd0, in_code_unit};
    end
  end

  // Encoded length and room check, one byte kept for the terminator
  always_comb begin
    if (cp <= 21'h00007f)      n = 3'd1;
    else if (cp <= 21'h0007ff) n = 3'd2;
    else if (cp <= 21'h00ffff) n = 3'd3;
    else                       n = 3'd4;
  end

  assign bw_sum = {1'b0, bw_r} + {14'd0, n};
  assign fits   = bw_sum < {1'b0, cap_r};
  assign stop   = have_cp && ((cp == 21'd0) || !fits);

  // Job and string state update
  always_comb begin
    pending_nxt = pending_r;
    high_nxt    = high_r;
    bw_nxt      = bw_r;
    halted_nxt  = halted_r;
    q_push      = 1'b0;
    q_job.cp     = cp;
    q_job.nbytes = 3'd0;
    q_job.term   = stop || in_end_of_string;
    if (accept) begin
      if (halted_r) begin
        if (in_end_of_string) begin
          pending_nxt = 1'b0;
          high_nxt    = 10'd0;
          bw_nxt      = 16'd0;
          halted_nxt  = 1'b0;
        end
      end else if (!have_cp) begin
        pending_nxt = 1'b1;
        high_nxt    = in_code_unit[9:0];
      end else begin
        pending_nxt = 1'b0;
        if (!stop) begin
          q_job.nbytes = n;
          bw_nxt       = bw_sum[15:0];
        end
        q_push = !stop || q_job.term;
        if (in_end_of_string) begin
          high_nxt   = 10'd0;
          bw_nxt     = 16'd0;
          halted_nxt = 1'b0;
        end else if (stop) begin
          halted_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= CAP_RESET;
      pending_r <= 1'b0;
      high_r    <= 10'd0;
      bw_r      <= 16'd0;
      halted_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) cap_r <= cfg_wr_data;
      pending_r <= pending_nxt;
      high_r    <= high_nxt;
      bw_r      <= bw_nxt;
      halted_r  <= halted_nxt;
    end
  end

endmodule

// ===== rtl/core/u16u8_fifo.sv =====
module u16u8_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  u16u8_pkg::job_t wr_job,
  output logic            full,
  input  logic            rd_en,
  output u16u8_pkg::job_t rd_job,
  output logic            empty
);
  import u16u8_pkg::*;

  job_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0] count_r;
  logic            do_wr, do_rd;

  assign full   = (count_r == Q_CW'(Q_DEPTH));
  assign empty  = (count_r == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_job = mem[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr_r] <= wr_job;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_wr && !do_rd)      count_r <= count_r + 1'b1;
      else if (do_rd && !do_wr) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ===== rtl/core/u16u8_back.sv =====
module u16u8_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  u16u8_pkg::job_t q_job,
  output logic            q_pop,
  input  logic            pop,
  output logic            empty,
  output logic [7:0]      out_out_byte,
  output logic            out_is_last
);
  import u16u8_pkg::*;

  logic [2:0] idx_r;
  logic [2:0] total;
  logic       in_data;
  logic       last_byte;
  logic       take;

  assign empty     = q_empty;
  assign total     = q_job.nbytes + {2'd0, q_job.term};
  assign in_data   = idx_r < q_job.nbytes;
  assign last_byte = (idx_r == total - 3'd1);
  assign take      = pop && !q_empty;
  assign q_pop     = take && last_byte;

  // Current byte of the head job: data bytes, then the terminator
  assign out_out_byte = in_data ? utf8_byte(q_job.cp, q_job.nbytes, idx_r[1:0]) : 8'h00;
  assign out_is_last  = !in_data;

  // Byte position within the head job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 3'd0;
    end else if (take) begin
      idx_r <= last_byte ? 3'd0 : idx_r + 3'd1;
    end
  end

endmodule

// ===== rtl/core/u16u8_checker.sv =====
`include "utf16le_to_utf8_converter_assert.svh"

module u16u8_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_wr_en,
  input logic [15:0] cfg_wr_data,
  input logic        push,
  input logic        full,
  input logic [15:0] in_code_unit,
  input logic        in_end_of_string,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  out_out_byte,
  input logic        out_is_last
);

  // Reset leaves the job queue empty and not full
  `U16U8_ASSERT_RST(a_reset_empty, !rst_n |=> empty && !full, "not empty after reset")

  // Terminator is always a zero byte
  `U16U8_ASSERT(a_last_zero, !empty && out_is_last |-> out_out_byte == 8'h00, "bad terminator")

  // Data bytes are never zero
  `U16U8_ASSERT(a_data_nonzero, !empty && !out_is_last |-> out_out_byte != 8'h00, "zero data byte")

  // Waiting result item holds until popped
  `U16U8_ASSERT(a_hold, !empty && !pop |=> !empty && $stable(out_out_byte) && $stable(out_is_last), "result changed while stalled")

endmodule

bind utf16le_to_utf8_converter u16u8_checker u_chk (.*);
